// ----- hw/rtl/spbs_pkg.sv -----
// ----------------------------------------------------------------------------
// spbs_pkg
// Shared types, register indexes and the direct-gain table for the stereo
// pan / balance / surround stage.
// ----------------------------------------------------------------------------
package spbs_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_PAN      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VOLUME   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BALANCE  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SURROUND = 2'd3;

  typedef enum logic [1:0] {
    MODE_STRAIGHT,
    MODE_SWAP,
    MODE_MONO,
    MODE_MIX
  } pan_mode_t;

  typedef struct packed {
    pan_mode_t   mode;
    logic [15:0] gd;   // direct gain, unsigned Q0.16
    logic [15:0] gc;   // cross gain, unsigned Q0.16
  } pan_cfg_t;

  typedef struct packed {
    logic [8:0] side_f;  // first side gain, x/256
    logic [8:0] side_s;  // second side gain, x/256
    logic       surround;
  } gain_cfg_t;

  localparam int unsigned GdNum = 4194304;  // 64 * 2^16

  // floor(64 * 2^16 / (128 - a)), indexed by a = |pan|
  localparam logic [15:0] GD_LUT [64] = '{
    16'(GdNum / 128), 16'(GdNum / 127), 16'(GdNum / 126), 16'(GdNum / 125),
    16'(GdNum / 124), 16'(GdNum / 123), 16'(GdNum / 122), 16'(GdNum / 121),
    16'(GdNum / 120), 16'(GdNum / 119), 16'(GdNum / 118), 16'(GdNum / 117),
    16'(GdNum / 116), 16'(GdNum / 115), 16'(GdNum / 114), 16'(GdNum / 113),
    16'(GdNum / 112), 16'(GdNum / 111), 16'(GdNum / 110), 16'(GdNum / 109),
    16'(GdNum / 108), 16'(GdNum / 107), 16'(GdNum / 106), 16'(GdNum / 105),
    16'(GdNum / 104), 16'(GdNum / 103), 16'(GdNum / 102), 16'(GdNum / 101),
    16'(GdNum / 100), 16'(GdNum / 99),  16'(GdNum / 98),  16'(GdNum / 97),
    16'(GdNum / 96),  16'(GdNum / 95),  16'(GdNum / 94),  16'(GdNum / 93),
    16'(GdNum / 92),  16'(GdNum / 91),  16'(GdNum / 90),  16'(GdNum / 89),
    16'(GdNum / 88),  16'(GdNum / 87),  16'(GdNum / 86),  16'(GdNum / 85),
    16'(GdNum / 84),  16'(GdNum / 83),  16'(GdNum / 82),  16'(GdNum / 81),
    16'(GdNum / 80),  16'(GdNum / 79),  16'(GdNum / 78),  16'(GdNum / 77),
    16'(GdNum / 76),  16'(GdNum / 75),  16'(GdNum / 74),  16'(GdNum / 73),
    16'(GdNum / 72),  16'(GdNum / 71),  16'(GdNum / 70),  16'(GdNum / 69),
    16'(GdNum / 68),  16'(GdNum / 67),  16'(GdNum / 66),  16'(GdNum / 65)
  };

endpackage

// ----- hw/rtl/spbs_cfg.sv -----
// ----------------------------------------------------------------------------
// spbs_cfg
// Configuration registers and the registered gains derived from them.
// ----------------------------------------------------------------------------
module spbs_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [spbs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [spbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output spbs_pkg::pan_cfg_t                 pan_cfg,
  output spbs_pkg::gain_cfg_t                gain_cfg
);

  logic signed [7:0] pan_r, bal_r;
  logic [6:0]        vol_r;
  logic              sur_r;

  spbs_pkg::pan_cfg_t  pan_cfg_r, pan_cfg_nxt;
  spbs_pkg::gain_cfg_t gain_cfg_r, gain_cfg_nxt;

  logic signed [7:0] pan_c, bal_c;
  logic [6:0]        pan_mag, bal_mag, vol_c;
  logic [13:0]       att_prod;
  logic [8:0]        att, vol4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r <= 8'sd64;
      vol_r <= 7'd64;
      bal_r <= 8'sd0;
      sur_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        spbs_pkg::REG_PAN:      pan_r <= $signed(cfg_wdata);
        spbs_pkg::REG_VOLUME:   vol_r <= cfg_wdata[6:0];
        spbs_pkg::REG_BALANCE:  bal_r <= $signed(cfg_wdata);
        spbs_pkg::REG_SURROUND: sur_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pan_c = (pan_r < -8'sd64) ? -8'sd64 : ((pan_r > 8'sd64) ? 8'sd64 : pan_r);
    bal_c = (bal_r < -8'sd64) ? -8'sd64 : ((bal_r > 8'sd64) ? 8'sd64 : bal_r);
    vol_c = (vol_r > 7'd64) ? 7'd64 : vol_r;
    pan_mag = pan_c[7] ? 7'(-pan_c) : pan_c[6:0];
    bal_mag = bal_c[7] ? 7'(-bal_c) : bal_c[6:0];

    if (pan_mag == 7'd64) begin
      pan_cfg_nxt.mode = pan_c[7] ? spbs_pkg::MODE_SWAP : spbs_pkg::MODE_STRAIGHT;
    end else if (pan_mag == 7'd0) begin
      pan_cfg_nxt.mode = spbs_pkg::MODE_MONO;
    end else begin
      pan_cfg_nxt.mode = spbs_pkg::MODE_MIX;
    end
    pan_cfg_nxt.gd = spbs_pkg::GD_LUT[pan_mag[5:0]];
    pan_cfg_nxt.gc = {7'd64 - pan_mag, 9'b0};

    // (4*vol * (64-|b|)) >> 6 == (vol * (64-|b|)) >> 4
    att_prod = 14'(vol_c) * 14'(7'd64 - bal_mag);
    att      = att_prod[12:4];
    vol4     = {vol_c, 2'b00};
    gain_cfg_nxt.side_f   = bal_c[7] ? vol4 : att;
    gain_cfg_nxt.side_s   = bal_c[7] ? att : vol4;
    gain_cfg_nxt.surround = sur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_cfg_r  <= '{mode: spbs_pkg::MODE_STRAIGHT, gd: '0, gc: '0};
      gain_cfg_r <= '{side_f: 9'd256, side_s: 9'd256, surround: 1'b0};
    end else begin
      pan_cfg_r  <= pan_cfg_nxt;
      gain_cfg_r <= gain_cfg_nxt;
    end
  end

  assign pan_cfg  = pan_cfg_r;
  assign gain_cfg = gain_cfg_r;

  a_mix_gain_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pan_cfg_r.mode == spbs_pkg::MODE_MIX) |-> (pan_cfg_r.gd > pan_cfg_r.gc))
    else $error("direct gain not above cross gain in mix mode");

  a_side_max: assert property (@(posedge clk) disable iff (!rst_n)
    (gain_cfg_r.side_f <= 9'd256) && (gain_cfg_r.side_s <= 9'd256))
    else $error("side gain above unity");

  a_one_side_cut: assert property (@(posedge clk) disable iff (!rst_n)
    (gain_cfg_r.side_f == 9'd256) |-> (gain_cfg_r.side_s <= 9'd256))
    else $error("side gains inconsistent");

  a_surround_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_addr == spbs_pkg::REG_SURROUND))
      |-> ##2 (gain_cfg_r.surround == $past(cfg_wdata[0], 2)))
    else $error("surround flag did not follow write");

endmodule

// ----- hw/rtl/spbs_pan.sv -----
// ----------------------------------------------------------------------------
// spbs_pan
// Five-stage pan cross-mix: second channel first, then the first channel fed
// with the new second value; swap, straight and mono paths run alongside.
// ----------------------------------------------------------------------------
module spbs_pan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spbs_pkg::pan_cfg_t        pan_cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        first_in,
  input  logic signed [15:0]        second_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [16:0]        first_mix,
  output logic signed [16:0]        second_mix
);

  logic [4:0] v_r, v_nxt, adv;

  logic signed [16:0] gd_s, gc_s;

  // stage a: input
  logic signed [15:0] fa_r, sa_r;
  // stage b: first products
  logic signed [32:0] pb_sd_r, pb_fc_r;
  logic signed [15:0] fb_r, sb_r;
  // stage c: new second value, mono average
  logic signed [33:0] sum_c, adj_c;
  logic signed [16:0] sum_m, adj_m;
  logic signed [16:0] sc_r;
  logic signed [15:0] fc_r, sc_raw_r, avg_c_r;
  // stage d: second products
  logic signed [33:0] pd_fd_r, pd_sc_r;
  logic signed [16:0] sd_r;
  logic signed [15:0] fd_raw_r, sd_raw_r, avg_d_r;
  // stage e: selected result
  logic signed [34:0] sum_e, adj_e;
  logic signed [16:0] fe_r, se_r, fe_nxt, se_nxt;

  assign gd_s = $signed({1'b0, pan_cfg.gd});
  assign gc_s = $signed({1'b0, pan_cfg.gc});

  always_comb begin
    adv[4] = !v_r[4] || out_ready;
    for (int k = 3; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt = {v_r[3:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < 5; k++) begin
        if (adv[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  assign in_ready = adv[0];

  always_comb begin
    sum_c = 34'(pb_sd_r) + 34'(pb_fc_r);
    adj_c = sum_c + (sum_c[33] ? 34'sd65535 : 34'sd0);
    sum_m = 17'(fb_r) + 17'(sb_r);
    adj_m = sum_m + (sum_m[16] ? 17'sd1 : 17'sd0);
    sum_e = 35'(pd_fd_r) + 35'(pd_sc_r);
    adj_e = sum_e + (sum_e[34] ? 35'sd65535 : 35'sd0);

    case (pan_cfg.mode)
      spbs_pkg::MODE_STRAIGHT: begin
        fe_nxt = 17'(fd_raw_r);
        se_nxt = 17'(sd_raw_r);
      end
      spbs_pkg::MODE_SWAP: begin
        fe_nxt = 17'(sd_raw_r);
        se_nxt = 17'(fd_raw_r);
      end
      spbs_pkg::MODE_MONO: begin
        fe_nxt = 17'(avg_d_r);
        se_nxt = 17'(avg_d_r);
      end
      default: begin
        fe_nxt = adj_e[32:16];
        se_nxt = sd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      fa_r <= first_in;
      sa_r <= second_in;
    end
    if (adv[1]) begin
      pb_sd_r <= sa_r * gd_s;
      pb_fc_r <= fa_r * gc_s;
      fb_r    <= fa_r;
      sb_r    <= sa_r;
    end
    if (adv[2]) begin
      sc_r     <= adj_c[32:16];
      fc_r     <= fb_r;
      sc_raw_r <= sb_r;
      avg_c_r  <= adj_m[16:1];
    end
    if (adv[3]) begin
      pd_fd_r  <= fc_r * gd_s;
      pd_sc_r  <= sc_r * gc_s;
      sd_r     <= sc_r;
      fd_raw_r <= fc_r;
      sd_raw_r <= sc_raw_r;
      avg_d_r  <= avg_c_r;
    end
    if (adv[4]) begin
      fe_r <= fe_nxt;
      se_r <= se_nxt;
    end
  end

  assign out_valid  = v_r[4];
  assign first_mix  = fe_r;
  assign second_mix = se_r;

endmodule

// ----- hw/rtl/spbs_gain.sv -----
// ----------------------------------------------------------------------------
// spbs_gain
// Side gains, truncation toward zero, saturation and surround inversion;
// the last stage is the output register.
// ----------------------------------------------------------------------------
module spbs_gain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spbs_pkg::gain_cfg_t       gain_cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [16:0]        first_mix,
  input  logic signed [16:0]        second_mix,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               first_out,
  output logic [15:0]               second_out
);

  logic [1:0] v_r, adv;

  logic signed [26:0] pf_r, ps_r;
  logic signed [26:0] adj_f, adj_s;
  logic signed [18:0] q_f, q_s;
  logic [15:0]        sat_f, sat_s;
  logic [15:0]        first_r, second_r;

  assign adv[1]   = !v_r[1] || out_ready;
  assign adv[0]   = !v_r[0] || adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      if (adv[1]) v_r[1] <= v_r[0];
    end
  end

  always_comb begin
    adj_f = pf_r + (pf_r[26] ? 27'sd255 : 27'sd0);
    adj_s = ps_r + (ps_r[26] ? 27'sd255 : 27'sd0);
    q_f   = adj_f[26:8];
    q_s   = adj_s[26:8];
    if (q_f > 19'sd32767) begin
      sat_f = 16'h7fff;
    end else if (q_f < -19'sd32768) begin
      sat_f = 16'h8000;
    end else begin
      sat_f = q_f[15:0];
    end
    if (q_s > 19'sd32767) begin
      sat_s = 16'h7fff;
    end else if (q_s < -19'sd32768) begin
      sat_s = 16'h8000;
    end else begin
      sat_s = q_s[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pf_r <= first_mix * $signed({1'b0, gain_cfg.side_f});
      ps_r <= second_mix * $signed({1'b0, gain_cfg.side_s});
    end
    if (adv[1]) begin
      first_r  <= sat_f;
      second_r <= gain_cfg.surround ? ~sat_s : sat_s;
    end
  end

  assign out_valid  = v_r[1];
  assign first_out  = first_r;
  assign second_out = second_r;

endmodule

// ----- hw/rtl/stereo_pan_balance_surround.sv -----
// ----------------------------------------------------------------------------
// stereo_pan_balance_surround
// Stereo pan cross-mix, volume/balance gains and surround inversion.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stereo frame per transaction, tdata = {second_in, first_in}.
//   out_* : one processed frame per input frame, same packing.
//   cfg_* : register writes (0 pan, 1 volume, 2 balance, 3 surround), taken
//           at any edge with cfg_we high; write only while the block is idle.
// Throughput: one frame per cycle while the receiver keeps out_tready high;
// the seven register stages (five in the pan cross-mix, two in the
// gain/saturation stage) each hold one frame, and frames pass them in order.
// Stalls: each stage moves only when the one after it is empty or moving, so
// a stalled receiver fills the pipe stage by stage; in_tready stays high
// while any stage has room. Nothing is dropped or repeated.
// Reset: all stages empty, pan 64 (straight), volume 64, balance 0, surround
// off. Derived gains are registered: they change in the cycle after the registers.
// ----------------------------------------------------------------------------
module stereo_pan_balance_surround (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // first_in, second_in
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,  // first_out, second_out
  input  logic                               cfg_we,
  input  logic [spbs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [spbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  spbs_pkg::pan_cfg_t  pan_cfg;
  spbs_pkg::gain_cfg_t gain_cfg;

  logic               mix_valid, mix_ready;
  logic signed [16:0] first_mix, second_mix;
  logic [15:0]        first_out, second_out;

  spbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .pan_cfg   (pan_cfg),
    .gain_cfg  (gain_cfg)
  );

  spbs_pan u_pan (
    .clk        (clk),
    .rst_n      (rst_n),
    .pan_cfg    (pan_cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .first_in   ($signed(in_tdata[15:0])),
    .second_in  ($signed(in_tdata[31:16])),
    .out_valid  (mix_valid),
    .out_ready  (mix_ready),
    .first_mix  (first_mix),
    .second_mix (second_mix)
  );

  spbs_gain u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain_cfg   (gain_cfg),
    .in_valid   (mix_valid),
    .in_ready   (mix_ready),
    .first_mix  (first_mix),
    .second_mix (second_mix),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .first_out  (first_out),
    .second_out (second_out)
  );

  assign out_tdata = {second_out, first_out};

endmodule
